>>> sv/bfiq_pkg.sv
// Package for the Bloom filter insert and query block.
// Holds the shared constants, operation codes, register map, state type and config struct.
// No dependencies.
package bfiq_pkg;

    localparam int MAX_FILTER_BITS = 65536;
    localparam int MAX_PROBES      = 30;
    localparam int MIN_FILTER_BITS = 64;
    localparam int FB_W            = 17;
    localparam int PC_W            = 5;
    localparam int HASH_W          = 32;
    localparam int OP_W            = 2;
    localparam int BYTE_W          = 8;
    localparam int DELTA_ROT       = 17;
    localparam int APB_AW          = 3;
    localparam int APB_DW          = 32;

    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

    localparam logic [APB_AW-3:0] REG_FILTER_BITS = 1'b0;
    localparam logic [APB_AW-3:0] REG_PROBE_COUNT = 1'b1;

    typedef struct packed {
        logic [FB_W-1:0] filter_bits;
        logic [PC_W-1:0] probe_count;
    } t_cfg;

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_MOD_H,
        S_MOD_D,
        S_MOD_C,
        S_RD,
        S_USE,
        S_WRAP,
        S_DONE
    } t_state;

endpackage

>>> sv/bfiq_cfg.sv
// Configuration register file with an APB-style port.
// Holds filter_bits and probe_count; depends on bfiq_pkg.
module bfiq_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bfiq_pkg::APB_AW-1:0]   paddr,
    input  logic [bfiq_pkg::APB_DW-1:0]   pwdata,
    output logic [bfiq_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    output bfiq_pkg::t_cfg                o_cfg
);

    logic [bfiq_pkg::FB_W-1:0]     r_filter_bits;
    logic [bfiq_pkg::PC_W-1:0]     r_probe_count;
    logic [bfiq_pkg::APB_AW-3:0]   w_index;
    logic                          w_wr;

    assign pready  = 1'b1;
    assign w_index = paddr[bfiq_pkg::APB_AW-1:2];
    assign w_wr    = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_bits <= bfiq_pkg::FB_W'(64);
            r_probe_count <= bfiq_pkg::PC_W'(1);
        end else if (w_wr) begin
            if (w_index == bfiq_pkg::REG_FILTER_BITS) begin
                r_filter_bits <= pwdata[bfiq_pkg::FB_W-1:0];
            end
            if (w_index == bfiq_pkg::REG_PROBE_COUNT) begin
                r_probe_count <= pwdata[bfiq_pkg::PC_W-1:0];
            end
        end
    end

    always_comb begin
        unique case (w_index)
            bfiq_pkg::REG_FILTER_BITS: prdata = bfiq_pkg::APB_DW'(r_filter_bits);
            bfiq_pkg::REG_PROBE_COUNT: prdata = bfiq_pkg::APB_DW'(r_probe_count);
            default:                   prdata = '0;
        endcase
    end

    assign o_cfg.filter_bits = r_filter_bits;
    assign o_cfg.probe_count = r_probe_count;

endmodule

>>> sv/bfiq_mod.sv
// Shared iterative modulo unit: 32-bit dividend reduced by the filter size, one bit a cycle.
// Depends on bfiq_pkg.
module bfiq_mod #(
    parameter int POS_W = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [bfiq_pkg::HASH_W-1:0]   i_dividend,
    input  logic [POS_W:0]                i_divisor,
    output logic                          o_done,
    output logic [POS_W-1:0]              o_rem
);

    localparam int CNT_W = $clog2(bfiq_pkg::HASH_W);

    logic                          r_busy;
    logic                          r_done;
    logic [CNT_W-1:0]              r_cnt;
    logic [bfiq_pkg::HASH_W-1:0]   r_dvd;
    logic [POS_W-1:0]              r_rem;
    logic [POS_W:0]                w_shift;
    logic [POS_W:0]                w_diff;

    assign w_shift = {r_rem, r_dvd[bfiq_pkg::HASH_W-1]};
    assign w_diff  = w_shift - i_divisor;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_W'(bfiq_pkg::HASH_W - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(bfiq_pkg::HASH_W - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[bfiq_pkg::HASH_W-2:0], 1'b0};
            r_rem <= (w_shift >= i_divisor) ? w_diff[POS_W-1:0] : w_shift[POS_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

>>> sv/bfiq_mem.sv
// Single-port byte memory that holds the filter bit array, with registered read data.
// Depends on bfiq_pkg.
module bfiq_mem #(
    parameter int DEPTH  = 8192,
    parameter int ADDR_W = 13
) (
    input  logic                          i_clk,
    input  logic [ADDR_W-1:0]             i_addr,
    input  logic                          i_we,
    input  logic [bfiq_pkg::BYTE_W-1:0]   i_wdata,
    output logic [bfiq_pkg::BYTE_W-1:0]   o_rdata
);

    logic [bfiq_pkg::BYTE_W-1:0] r_mem [DEPTH];
    logic [bfiq_pkg::BYTE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/bloom_filter_insert_query.sv
// Bloom filter with double hashing over an on-chip bit array. After reset, and for every
// clear operation, the array is zeroed one byte a cycle, all MAX_FILTER_BITS/8 bytes (8192
// at the default size), and no transfer is taken meanwhile. For an insert or query the shared
// bit-serial modulo unit reduces in turn the key hash, the probe step and the 2^32 wrap term;
// each probe, around the single memory port, reads its byte, tests or sets its bit and, unless
// it ends the operation, steps to the next position. The unused operation answers may_match 0.
// Depends on bfiq_pkg, bfiq_cfg, bfiq_mod and bfiq_mem.
module bloom_filter_insert_query #(
    parameter int MAX_FILTER_BITS = bfiq_pkg::MAX_FILTER_BITS,
    parameter int MAX_PROBES      = bfiq_pkg::MAX_PROBES
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [31:0]                   s_axis_tdata,  // [31:0] key_hash
    input  logic [1:0]                    s_axis_tuser,  // [1:0] op
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [7:0]                    m_axis_tdata,  // [0] may_match, [7:1] zero
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bfiq_pkg::APB_AW-1:0]   paddr,
    input  logic [bfiq_pkg::APB_DW-1:0]   pwdata,
    output logic [bfiq_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);

    localparam int DEPTH  = MAX_FILTER_BITS / bfiq_pkg::BYTE_W;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int POS_W  = $clog2(MAX_FILTER_BITS);
    localparam int BITS_W = POS_W + 1;
    localparam int CNT_W  = $clog2(MAX_PROBES + 1);
    localparam int HW     = bfiq_pkg::HASH_W;
    localparam int FW     = bfiq_pkg::FB_W;

    bfiq_pkg::t_cfg                w_cfg;
    bfiq_pkg::t_state              r_state, n_state;

    logic [ADDR_W-1:0]             r_clr_cnt, n_clr_cnt;
    logic                          r_clr_rsp, n_clr_rsp;
    logic                          r_ins, n_ins;
    logic [HW-1:0]                 r_hash, n_hash;
    logic [HW-1:0]                 r_delta, n_delta;
    logic [BITS_W-1:0]             r_bits, n_bits;
    logic [POS_W-1:0]              r_pos, n_pos;
    logic [POS_W-1:0]              r_dmod, n_dmod;
    logic [POS_W-1:0]              r_cmod, n_cmod;
    logic                          r_carry, n_carry;
    logic [CNT_W-1:0]              r_left, n_left;
    logic                          r_match, n_match;
    logic [2:0]                    r_bitsel, n_bitsel;
    logic                          r_out_valid;
    logic                          r_out_match;
    logic                          w_out_load;

    logic                          w_mod_start;
    logic [HW-1:0]                 w_mod_dvd;
    logic                          w_mod_done;
    logic [POS_W-1:0]              w_mod_rem;

    logic [ADDR_W-1:0]             w_mem_addr;
    logic                          w_mem_we;
    logic [bfiq_pkg::BYTE_W-1:0]   w_mem_wdata;
    logic [bfiq_pkg::BYTE_W-1:0]   w_mem_rdata;

    logic [FW:0]                   w_fb_min;
    logic [FW:0]                   w_fb_rnd;
    logic [BITS_W-1:0]             w_eff_bits;
    logic [CNT_W-1:0]              w_eff_probes;
    logic [HW-1:0]                 w_in_delta;
    logic [BITS_W-1:0]             w_c1;
    logic [POS_W:0]                w_sum;
    logic [POS_W-1:0]              w_step;
    logic [POS_W:0]                w_wrap_up;
    logic [POS_W-1:0]              w_wrap;
    logic [HW:0]                   w_hash_add;
    logic [bfiq_pkg::BYTE_W-1:0]   w_mask;

    bfiq_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    bfiq_mod #(
        .POS_W (POS_W)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_mod_start),
        .i_dividend (w_mod_dvd),
        .i_divisor  (r_bits),
        .o_done     (w_mod_done),
        .o_rem      (w_mod_rem)
    );

    bfiq_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_addr  (w_mem_addr),
        .i_we    (w_mem_we),
        .i_wdata (w_mem_wdata),
        .o_rdata (w_mem_rdata)
    );

    // Filter size and probe count as used: clamped and rounded up to whole bytes.
    always_comb begin
        w_fb_min = (w_cfg.filter_bits < FW'(bfiq_pkg::MIN_FILTER_BITS))
                 ? (FW+1)'(bfiq_pkg::MIN_FILTER_BITS) : {1'b0, w_cfg.filter_bits};
        w_fb_rnd = (w_fb_min + (FW+1)'(7)) & ~((FW+1)'(7));
        w_eff_bits = (32'(w_fb_rnd) > 32'(MAX_FILTER_BITS))
                   ? BITS_W'(MAX_FILTER_BITS) : BITS_W'(w_fb_rnd);
        if (w_cfg.probe_count == '0) begin
            w_eff_probes = CNT_W'(1);
        end else if (32'(w_cfg.probe_count) > 32'(MAX_PROBES)) begin
            w_eff_probes = CNT_W'(MAX_PROBES);
        end else begin
            w_eff_probes = CNT_W'(w_cfg.probe_count);
        end
    end

    assign w_in_delta = (s_axis_tdata >> bfiq_pkg::DELTA_ROT)
                      | (s_axis_tdata << (HW - bfiq_pkg::DELTA_ROT));

    // The next probe position is the old one plus the step, less 2^32 mod size on a wrap.
    assign w_c1       = {1'b0, w_mod_rem} + BITS_W'(1);
    assign w_sum      = {1'b0, r_pos} + {1'b0, r_dmod};
    assign w_step     = (w_sum >= r_bits) ? POS_W'(w_sum - r_bits) : w_sum[POS_W-1:0];
    assign w_wrap_up  = {1'b0, r_pos} + r_bits - {1'b0, r_cmod};
    assign w_wrap     = (r_pos >= r_cmod) ? (r_pos - r_cmod) : w_wrap_up[POS_W-1:0];
    assign w_hash_add = {1'b0, r_hash} + {1'b0, r_delta};
    assign w_mask     = bfiq_pkg::BYTE_W'(1) << r_bitsel;

    assign s_axis_tready = (r_state == bfiq_pkg::S_IDLE);

    always_comb begin
        n_state     = r_state;
        n_clr_cnt   = r_clr_cnt;
        n_clr_rsp   = r_clr_rsp;
        n_ins       = r_ins;
        n_hash      = r_hash;
        n_delta     = r_delta;
        n_bits      = r_bits;
        n_pos       = r_pos;
        n_dmod      = r_dmod;
        n_cmod      = r_cmod;
        n_carry     = r_carry;
        n_left      = r_left;
        n_match     = r_match;
        n_bitsel    = r_bitsel;
        w_mod_start = 1'b0;
        w_mod_dvd   = s_axis_tdata;
        w_mem_addr  = r_pos[POS_W-1:3];
        w_mem_we    = 1'b0;
        w_mem_wdata = w_mem_rdata | w_mask;
        w_out_load  = 1'b0;

        unique case (r_state)
            bfiq_pkg::S_CLR: begin
                w_mem_addr  = r_clr_cnt;
                w_mem_we    = 1'b1;
                w_mem_wdata = '0;
                n_clr_cnt   = r_clr_cnt + ADDR_W'(1);
                if (r_clr_cnt == ADDR_W'(DEPTH - 1)) begin
                    n_clr_cnt = '0;
                    n_clr_rsp = 1'b0;
                    n_match   = 1'b0;
                    n_state   = r_clr_rsp ? bfiq_pkg::S_DONE : bfiq_pkg::S_IDLE;
                end
            end
            bfiq_pkg::S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_hash  = s_axis_tdata;
                    n_delta = w_in_delta;
                    n_bits  = w_eff_bits;
                    n_left  = w_eff_probes;
                    n_ins   = (s_axis_tuser == bfiq_pkg::OP_INSERT);
                    n_match = (s_axis_tuser == bfiq_pkg::OP_QUERY);
                    if (s_axis_tuser == bfiq_pkg::OP_CLEAR) begin
                        n_clr_cnt = '0;
                        n_clr_rsp = 1'b1;
                        n_state   = bfiq_pkg::S_CLR;
                    end else if (s_axis_tuser == bfiq_pkg::OP_INSERT
                              || s_axis_tuser == bfiq_pkg::OP_QUERY) begin
                        w_mod_start = 1'b1;
                        n_state     = bfiq_pkg::S_MOD_H;
                    end else begin
                        n_state = bfiq_pkg::S_DONE;
                    end
                end
            end
            bfiq_pkg::S_MOD_H: begin
                w_mod_dvd = r_delta;
                if (w_mod_done) begin
                    n_pos       = w_mod_rem;
                    w_mod_start = 1'b1;
                    n_state     = bfiq_pkg::S_MOD_D;
                end
            end
            bfiq_pkg::S_MOD_D: begin
                w_mod_dvd = '1;
                if (w_mod_done) begin
                    n_dmod      = w_mod_rem;
                    w_mod_start = 1'b1;
                    n_state     = bfiq_pkg::S_MOD_C;
                end
            end
            bfiq_pkg::S_MOD_C: begin
                if (w_mod_done) begin
                    n_cmod  = (w_c1 == r_bits) ? '0 : w_c1[POS_W-1:0];
                    n_state = bfiq_pkg::S_RD;
                end
            end
            bfiq_pkg::S_RD: begin
                n_bitsel = r_pos[2:0];
                n_state  = bfiq_pkg::S_USE;
            end
            bfiq_pkg::S_USE: begin
                w_mem_we = r_ins;
                if (!r_ins && ((w_mem_rdata & w_mask) == '0)) begin
                    n_match = 1'b0;
                    n_state = bfiq_pkg::S_DONE;
                end else if (r_left == CNT_W'(1)) begin
                    n_state = bfiq_pkg::S_DONE;
                end else begin
                    n_left  = r_left - CNT_W'(1);
                    n_hash  = w_hash_add[HW-1:0];
                    n_carry = w_hash_add[HW];
                    n_pos   = w_step;
                    n_state = bfiq_pkg::S_WRAP;
                end
            end
            bfiq_pkg::S_WRAP: begin
                if (r_carry) begin
                    n_pos = w_wrap;
                end
                n_state = bfiq_pkg::S_RD;
            end
            bfiq_pkg::S_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    w_out_load = 1'b1;
                    n_state    = bfiq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bfiq_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= bfiq_pkg::S_CLR;
            r_clr_cnt <= '0;
            r_clr_rsp <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr_cnt <= n_clr_cnt;
            r_clr_rsp <= n_clr_rsp;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ins    <= n_ins;
        r_hash   <= n_hash;
        r_delta  <= n_delta;
        r_bits   <= n_bits;
        r_pos    <= n_pos;
        r_dmod   <= n_dmod;
        r_cmod   <= n_cmod;
        r_carry  <= n_carry;
        r_left   <= n_left;
        r_match  <= n_match;
        r_bitsel <= n_bitsel;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_match <= r_match;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'b0, r_out_match};

endmodule
